FILE: rtl/lge_pkg.sv
`timescale 1ns / 1ps
package lge_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int ROW_IW    = $clog2(GRID_ROWS);
  localparam int COL_IW    = $clog2(GRID_COLS);
  localparam int ADDR_W    = 5;
  localparam int CMP_W     = 10;

  typedef enum logic [1:0] {
    CELL_DEAD    = 2'd0,
    CELL_ALIVE   = 2'd1,
    CELL_NEWBORN = 2'd2
  } cell_t;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_FIN
  } state_t;

  // shared control from the sequencer to every column cell
  typedef struct packed {
    logic              gen;
    logic              top;
    logic              bottom;
    logic              wr;
    logic [ROW_IW-1:0] row;
    cell_t             wr_val;
  } cell_ctrl_t;

  function automatic cell_t next_cell(input cell_t s, input logic [3:0] n);
    cell_t t;
    begin
      t = s;
      if (s != CELL_DEAD && (n < 4'd2 || n > 4'd3)) begin
        t = CELL_DEAD;
      end else if (s == CELL_DEAD && n == 4'd3) begin
        t = CELL_NEWBORN;
      end else if (s == CELL_NEWBORN) begin
        t = CELL_ALIVE;
      end
      return t;
    end
  endfunction

endpackage

FILE: rtl/lge_in_if.sv
`timescale 1ns / 1ps
interface lge_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] row;
  logic [4:0] col;
  logic       alive_in;

  modport source (output valid, cmd, row, col, alive_in, input ready);
  modport sink   (input valid, cmd, row, col, alive_in, output ready);
endinterface

FILE: rtl/lge_out_if.sv
`timescale 1ns / 1ps
interface lge_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_state;

  modport source (output valid, cell_state, input ready);
  modport sink   (input valid, cell_state, output ready);
endinterface

FILE: rtl/lge_cell.sv
`timescale 1ns / 1ps
module lge_cell
  import lge_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  logic [2:0] left_win,
  input  logic [2:0] right_win,
  output logic [2:0] win,
  output cell_t      rd_val
);

  // one grid column as a rotating line: slot 0 is the row under update
  cell_t      line_r [GRID_ROWS];
  cell_t      line_nxt [GRID_ROWS];
  logic       prev_live_r;
  logic       prev_live_nxt;
  logic       above;
  logic       cur;
  logic       below;
  logic [3:0] n;
  cell_t      upd;

  assign above  = prev_live_r & ~ctrl.top;
  assign cur    = (line_r[0] != CELL_DEAD);
  assign below  = (line_r[1] != CELL_DEAD) & ~ctrl.bottom;
  assign win    = {above, cur, below};
  assign n      = 4'($countones({left_win, right_win, above, below}));
  assign upd    = next_cell(line_r[0], n);
  assign rd_val = line_r[ctrl.row];

  always_comb begin
    line_nxt      = line_r;
    prev_live_nxt = prev_live_r;
    if (ctrl.gen) begin
      for (int i = 0; i < GRID_ROWS - 1; i++) begin
        line_nxt[i] = line_r[i + 1];
      end
      line_nxt[GRID_ROWS - 1] = upd;
      prev_live_nxt           = cur;
    end else if (ctrl.wr && sel) begin
      line_nxt[ctrl.row] = ctrl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GRID_ROWS; i++) begin
        line_r[i] <= CELL_DEAD;
      end
      prev_live_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      prev_live_r <= prev_live_nxt;
    end
  end

endmodule

FILE: rtl/life_generation_engine_unit.sv
`timescale 1ns / 1ps
// Write and read: the result is in the output register in the cycle after accept.
// Advance: a sweep in ST_GEN (one row of all column cells per cycle), then the read in ST_FIN.
// One item is in work at a time; a new item is taken in the cycle its result leaves.
// Throughput: 1 item/cycle for reads and writes while out_ch.ready holds; no item is taken during an advance.
// Reset (rst_n, synchronous) clears every cell to dead and empties the output register.
module life_generation_engine_unit
  import lge_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lge_in_if.sink    in_ch,
  lge_out_if.source out_ch
);

  state_t            state_r;
  state_t            state_nxt;
  logic [ROW_IW-1:0] row_cnt_r;
  logic [ROW_IW-1:0] row_cnt_nxt;
  logic [ROW_IW-1:0] sv_row_r;
  logic [COL_IW-1:0] sv_col_r;
  logic              sv_inside_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  cell_t             out_state_r;
  cell_t             out_state_nxt;

  logic              in_acc;
  logic              in_inside;
  logic [ROW_IW-1:0] in_row_idx;
  logic [COL_IW-1:0] in_col_idx;
  logic [COL_IW-1:0] rd_col;
  logic              rd_inside;
  cell_ctrl_t        ctrl;
  logic              load_sv;

  logic [2:0]        win     [GRID_COLS];
  cell_t             rd_vals [GRID_COLS];
  cell_t             rd_cell;

  localparam logic [ROW_IW-1:0] LAST_ROW = ROW_IW'(GRID_ROWS - 1);

  assign in_row_idx = ROW_IW'(in_ch.row);
  assign in_col_idx = COL_IW'(in_ch.col);
  assign in_inside  = (CMP_W'(in_ch.row) < CMP_W'(GRID_ROWS)) &&
                      (CMP_W'(in_ch.col) < CMP_W'(GRID_COLS));

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_state = out_state_r;

  assign rd_col    = (state_r == ST_FIN) ? sv_col_r : in_col_idx;
  assign rd_inside = (state_r == ST_FIN) ? sv_inside_r : in_inside;
  assign rd_cell   = rd_inside ? rd_vals[rd_col] : CELL_DEAD;

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_state_nxt = out_state_r;
    load_sv       = 1'b0;
    ctrl.gen      = 1'b0;
    ctrl.top      = (row_cnt_r == '0);
    ctrl.bottom   = (row_cnt_r == LAST_ROW);
    ctrl.wr       = 1'b0;
    ctrl.row      = (state_r == ST_FIN) ? sv_row_r : in_row_idx;
    ctrl.wr_val   = in_ch.alive_in ? CELL_ALIVE : CELL_DEAD;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_ch.cmd))
            CMD_WRITE: begin
              ctrl.wr       = in_inside;
              out_valid_nxt = 1'b1;
              out_state_nxt = in_inside ? ctrl.wr_val : CELL_DEAD;
            end
            CMD_ADVANCE: begin
              load_sv     = 1'b1;
              row_cnt_nxt = '0;
              state_nxt   = ST_GEN;
            end
            default: begin
              // read, and the unused code acts as a read
              out_valid_nxt = 1'b1;
              out_state_nxt = rd_cell;
            end
          endcase
        end
      end
      ST_GEN: begin
        ctrl.gen    = 1'b1;
        row_cnt_nxt = row_cnt_r + 1'b1;
        if (row_cnt_r == LAST_ROW) begin
          row_cnt_nxt = '0;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        // output register is empty here: advance was taken only when it could drain
        out_valid_nxt = 1'b1;
        out_state_nxt = rd_cell;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_state_r <= out_state_nxt;
    if (load_sv) begin
      sv_row_r    <= in_row_idx;
      sv_col_r    <= in_col_idx;
      sv_inside_r <= in_inside;
    end
  end

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    logic [2:0] lw;
    logic [2:0] rw;
    if (c == 0) begin : g_l0
      assign lw = 3'b000;
    end else begin : g_l1
      assign lw = win[c - 1];
    end
    if (c == GRID_COLS - 1) begin : g_r0
      assign rw = 3'b000;
    end else begin : g_r1
      assign rw = win[c + 1];
    end
    lge_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sel       (in_col_idx == COL_IW'(c)),
      .left_win  (lw),
      .right_win (rw),
      .win       (win[c]),
      .rd_val    (rd_vals[c])
    );
  end

  a_no_out_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> !out_valid_r)
    else $error("result pending during generation sweep");

  a_adv_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_ADVANCE) |=> (state_r == ST_GEN && row_cnt_r == '0))
    else $error("advance did not start the sweep at row 0");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN && row_cnt_r != LAST_ROW) |=>
      (state_r == ST_GEN && row_cnt_r == $past(row_cnt_r) + 1'b1))
    else $error("sweep row counter skipped");

  a_rdwr_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd != CMD_ADVANCE) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("read or write gave no result");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("advance gave no result");

endmodule

FILE: tb/life_checker.sv
`timescale 1ns / 1ps
module life_checker
  import lge_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lge_in_if    in_mon,
  lge_out_if   out_mon,
  output int   mismatches,
  output int   outstanding
);

  cell_t life_grid [GRID_ROWS][GRID_COLS];
  cell_t expected_states [$];

  task automatic report(input string what);
    $display("[%0t] check error: %s", $time, what);
    mismatches++;
  endtask

  // cells off the grid count as dead, no wrap at the edges
  function automatic logic [3:0] count_live(input int r, input int c);
    logic [3:0] n;
    int nr, nc;
    n = '0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < GRID_ROWS && nc < GRID_COLS)
        begin
          if (life_grid[nr][nc] != CELL_DEAD) n++;
        end
      end
    end
    return n;
  endfunction

  task automatic step_generation();
    cell_t nxt [GRID_ROWS][GRID_COLS];
    logic [3:0] n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        n = count_live(r, c);
        if (life_grid[r][c] == CELL_DEAD) begin
          nxt[r][c] = (n == 4'd3) ? CELL_NEWBORN : CELL_DEAD;
        end else begin
          // survivors, newborn or not, are alive next generation
          nxt[r][c] = (n == 4'd2 || n == 4'd3) ? CELL_ALIVE : CELL_DEAD;
        end
      end
    end
    life_grid = nxt;
  endtask

  task automatic predict(input logic [1:0] cmd, input logic [4:0] row,
                         input logic [4:0] col, input logic alive);
    logic on_grid;
    on_grid = (row < GRID_ROWS) && (col < GRID_COLS);
    case (cmd)
      CMD_WRITE: begin
        if (on_grid) life_grid[row][col] = alive ? CELL_ALIVE : CELL_DEAD;
      end
      CMD_ADVANCE: begin
        step_generation();
      end
      default: ;  // read, and the spare code acts as a read
    endcase
    expected_states.push_back(on_grid ? life_grid[row][col] : CELL_DEAD);
  endtask

  always @(posedge clk) begin
    cell_t want;
    if (!rst_n) begin
      foreach (life_grid[r, c]) life_grid[r][c] = CELL_DEAD;
      expected_states.delete();
    end else begin
      // input first, so a same-edge result would still find its item
      if (in_mon.valid && in_mon.ready) begin
        predict(in_mon.cmd, in_mon.row, in_mon.col, in_mon.alive_in);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_states.size() == 0) begin
          report($sformatf("result %0d with no item pending", out_mon.cell_state));
        end else begin
          want = expected_states.pop_front();
          if (out_mon.cell_state !== want) begin
            report($sformatf("cell_state %0d, expected %0d", out_mon.cell_state, want));
          end
        end
      end
    end
    outstanding = expected_states.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lge_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         ITEM_TARGET = 1270;
  localparam int         IDLE_PCT    = 13;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  int   hold_reqs;
  int   cycle_count;

  lge_in_if  in_ch ();
  lge_out_if out_ch ();

  life_generation_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  life_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input logic [1:0] cmd, input logic [4:0] row,
                           input logic [4:0] col, input logic alive);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.row      <= row;
    in_ch.col      <= col;
    in_ch.alive_in <= alive;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // fill a small window, then let it evolve a few generations and look around
  task automatic life_episode();
    logic [4:0] r0, c0;
    int fills, gens, looks;
    r0 = 5'($urandom_range(0, 31));
    c0 = 5'($urandom_range(0, 31));
    fills = $urandom_range(4, 14);
    gens = $urandom_range(1, 3);
    for (int k = 0; k < fills; k++) begin
      send_item(CMD_WRITE, r0 + 5'($urandom_range(0, 4)), c0 + 5'($urandom_range(0, 4)),
                $urandom_range(99) < 80);
    end
    for (int g = 0; g < gens; g++) begin
      send_item(CMD_ADVANCE, r0 + 5'($urandom_range(0, 4)), c0 + 5'($urandom_range(0, 4)),
                1'($urandom));
      looks = $urandom_range(1, 3);
      for (int k = 0; k < looks; k++) begin
        send_item(($urandom_range(99) < 85) ? CMD_READ : CMD_SPARE,
                  r0 + 5'($urandom_range(0, 4)), c0 + 5'($urandom_range(0, 4)),
                  1'($urandom));
      end
    end
  endtask

  // receiver: random back-pressure plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("life_generation_engine_unit regression: fail");
    $finish;
  end

  initial begin
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    calm = 1'b0;
    items_sent = 0;
    hold_reqs = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_READ;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.alive_in = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, blinker, block completion, spare code
    send_item(CMD_READ, 5'd0, 5'd0, 1'b0);
    send_item(CMD_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(CMD_WRITE, 5'd31, 5'd31, 1'b1);
    send_item(CMD_WRITE, 5'd0, 5'd31, 1'b1);
    send_item(CMD_WRITE, 5'd31, 5'd0, 1'b1);
    send_item(CMD_WRITE, 5'd10, 5'd9, 1'b1);
    send_item(CMD_WRITE, 5'd10, 5'd10, 1'b1);
    send_item(CMD_WRITE, 5'd10, 5'd11, 1'b1);
    send_item(CMD_SPARE, 5'd10, 5'd10, 1'b1);
    send_item(CMD_ADVANCE, 5'd9, 5'd10, 1'b0);   // blinker turns, cell born
    send_item(CMD_READ, 5'd11, 5'd10, 1'b0);
    send_item(CMD_READ, 5'd0, 5'd0, 1'b0);       // lonely corner died
    send_item(CMD_READ, 5'd31, 5'd31, 1'b1);
    send_item(CMD_WRITE, 5'd20, 5'd20, 1'b1);
    send_item(CMD_WRITE, 5'd20, 5'd21, 1'b1);
    send_item(CMD_WRITE, 5'd21, 5'd20, 1'b1);
    send_item(CMD_ADVANCE, 5'd21, 5'd21, 1'b1);  // block corner is newborn
    send_item(CMD_ADVANCE, 5'd21, 5'd21, 1'b0);  // and now alive
    send_item(CMD_READ, 5'd10, 5'd9, 1'b0);
    send_item(CMD_WRITE, 5'd21, 5'd21, 1'b0);
    send_item(CMD_WRITE, 5'd15, 5'd15, 1'b0);
    send_item(CMD_SPARE, 5'd31, 5'd0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      if (!held && items_sent >= 300) begin
        held = 1'b1;
        hold_reqs++;
        // keep offering reads so the block backs up against the stalled output
        for (int k = 0; k < 12; k++) begin
          send_item(CMD_READ, 5'($urandom), 5'($urandom), 1'($urandom));
        end
      end
      if (!paused && items_sent >= 900) begin
        paused = 1'b1;
        drain();
      end
      calm = (items_sent >= 550 && items_sent < 750);
      if ($urandom_range(99) < 70) begin
        life_episode();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(2'($urandom_range(0, 3)), 5'($urandom), 5'($urandom), 1'($urandom));
        end
      end
    end

    calm = 1'b0;
    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("life_generation_engine_unit regression: pass");
    end else begin
      $display("life_generation_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
